// ----- sv/irsr_pkg.sv -----
package irsr_pkg;

   localparam int MAX_RATIO_DEFAULT = 24;

   localparam int RATE_WIDTH = 16;
   localparam int EFF_WIDTH  = RATE_WIDTH + 1;
   localparam int SAMPLE_WIDTH = 16;
   localparam int CSR_ADDR_WIDTH = 5;
   localparam int CSR_DATA_WIDTH = 32;

   localparam logic [RATE_WIDTH-1:0] RESET_RATE = 16'd11025;
   localparam logic [7:0] BYTE_BIAS = 8'd128;

   // register index, taken from paddr[4:2]
   localparam logic [2:0] REG_SOURCE_RATE   = 3'd0;
   localparam logic [2:0] REG_OUTPUT_RATE   = 3'd1;
   localparam logic [2:0] REG_SOURCE_STEREO = 3'd2;
   localparam logic [2:0] REG_OUTPUT_STEREO = 3'd3;
   localparam logic [2:0] REG_WIDE_SAMPLES  = 3'd4;

   // which ratio the divider is working out
   localparam logic [1:0] DIV_NONE = 2'd0;
   localparam logic [1:0] DIV_INC  = 2'd1;
   localparam logic [1:0] DIV_DUP  = 2'd2;

   typedef struct packed {
      logic div_init;
      logic div_step;
      logic accept;
      logic emit;
   } ctl_cmd_type;

   typedef struct packed {
      logic cfg_write;
      logic div_done;
      logic copies_zero;
   } ctl_status_type;

endpackage

// ----- sv/integer_ratio_sample_resampler_top.sv -----
// An accepted input word is registered in value_ff, then in rsp_pcm_ff as an output.
// Inputs stall until a kept input's copies are out (one output per cycle unless rsp_stall).
// A register write recomputes the ratios by repeated subtraction: inputs stall from the
// write until the divider is done.
// Reset (synchronous): registers to their defaults, both ratios to 1, no clearing pass.
module integer_ratio_sample_resampler_top #(
   parameter int MAX_RATIO = irsr_pkg::MAX_RATIO_DEFAULT
) (
   input  logic                                     clock,
   input  logic                                     reset,
   input  logic                                     req_valid,
   output logic                                     req_stall,
   input  logic [irsr_pkg::SAMPLE_WIDTH-1:0]        req_sample_bits,
   input  logic                                     req_sound_end,
   output logic                                     rsp_valid,
   input  logic                                     rsp_stall,
   output logic signed [irsr_pkg::SAMPLE_WIDTH-1:0] rsp_pcm_out,
   output logic                                     rsp_run_last,
   input  logic                                     csr_psel,
   input  logic                                     csr_penable,
   input  logic                                     csr_pwrite,
   input  logic [irsr_pkg::CSR_ADDR_WIDTH-1:0]      csr_paddr,
   input  logic [irsr_pkg::CSR_DATA_WIDTH-1:0]      csr_pwdata,
   output logic [irsr_pkg::CSR_DATA_WIDTH-1:0]      csr_prdata,
   output logic                                     csr_pready
);

   irsr_pkg::ctl_cmd_type    cmd;
   irsr_pkg::ctl_status_type status;

   assign csr_pready = 1'b1;

   irsr_controller u_controller (
      .clock     (clock),
      .reset     (reset),
      .status    (status),
      .cmd       (cmd),
      .req_valid (req_valid),
      .req_stall (req_stall)
   );

   irsr_datapath #(
      .MAX_RATIO (MAX_RATIO)
   ) u_datapath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .status          (status),
      .req_sample_bits (req_sample_bits),
      .req_sound_end   (req_sound_end),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_pcm_out     (rsp_pcm_out),
      .rsp_run_last    (rsp_run_last),
      .csr_psel        (csr_psel),
      .csr_penable     (csr_penable),
      .csr_pwrite      (csr_pwrite),
      .csr_paddr       (csr_paddr),
      .csr_pwdata      (csr_pwdata),
      .csr_prdata      (csr_prdata)
   );

endmodule

// ----- sv/irsr_datapath.sv -----
module irsr_datapath #(
   parameter int MAX_RATIO = irsr_pkg::MAX_RATIO_DEFAULT
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  irsr_pkg::ctl_cmd_type                cmd,
   output irsr_pkg::ctl_status_type             status,
   input  logic [irsr_pkg::SAMPLE_WIDTH-1:0]    req_sample_bits,
   input  logic                                 req_sound_end,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic signed [irsr_pkg::SAMPLE_WIDTH-1:0] rsp_pcm_out,
   output logic                                 rsp_run_last,
   input  logic                                 csr_psel,
   input  logic                                 csr_penable,
   input  logic                                 csr_pwrite,
   input  logic [irsr_pkg::CSR_ADDR_WIDTH-1:0]  csr_paddr,
   input  logic [irsr_pkg::CSR_DATA_WIDTH-1:0]  csr_pwdata,
   output logic [irsr_pkg::CSR_DATA_WIDTH-1:0]  csr_prdata
);

   localparam int QW = $clog2(MAX_RATIO + 1);
   localparam logic [QW-1:0] RATIO_MAX = QW'(MAX_RATIO);
   localparam logic [QW-1:0] RATIO_ONE = QW'(1);

   localparam int RW = irsr_pkg::RATE_WIDTH;
   localparam int EW = irsr_pkg::EFF_WIDTH;
   localparam int SW = irsr_pkg::SAMPLE_WIDTH;

   // configuration registers
   logic [RW-1:0] source_rate_ff, source_rate_in;
   logic [RW-1:0] output_rate_ff, output_rate_in;
   logic          source_stereo_ff, source_stereo_in;
   logic          output_stereo_ff, output_stereo_in;
   logic          wide_samples_ff, wide_samples_in;

   // ratio state
   logic [QW-1:0] step_ratio_ff, step_ratio_in;
   logic [QW-1:0] repeat_ratio_ff, repeat_ratio_in;
   logic [QW-1:0] skip_phase_ff, skip_phase_in;

   // divider
   logic [EW-1:0] rem_ff, rem_in;
   logic [EW-1:0] divisor_ff, divisor_in;
   logic [QW-1:0] quot_ff, quot_in;
   logic [1:0]    div_mode_ff, div_mode_in;

   // emit side
   logic [QW-1:0] copies_ff, copies_in;
   logic [SW-1:0] value_ff, value_in;
   logic          rsp_valid_ff, rsp_valid_in;
   logic [SW-1:0] rsp_pcm_ff, rsp_pcm_in;
   logic          rsp_last_ff, rsp_last_in;

   logic [2:0]    csr_index;
   logic          csr_wr;
   logic [EW-1:0] eff_rate;
   logic [EW-1:0] out_rate;
   logic          div_done;
   logic          emit_fire;
   logic [7:0]    byte_val;
   logic [SW-1:0] conv_val;

   assign csr_index = csr_paddr[4:2];
   assign csr_wr = csr_psel && csr_penable && csr_pwrite &&
                   (csr_index <= irsr_pkg::REG_WIDE_SAMPLES);

   // halve for mono into stereo, double for stereo into mono
   always_comb begin
      eff_rate = {1'b0, source_rate_ff};
      if (!source_stereo_ff && output_stereo_ff) begin
         eff_rate = {2'b00, source_rate_ff[RW-1:1]};
      end else if (source_stereo_ff && !output_stereo_ff) begin
         eff_rate = {source_rate_ff, 1'b0};
      end
   end
   assign out_rate = {1'b0, output_rate_ff};

   assign div_done = (rem_ff < divisor_ff) || (quot_ff == RATIO_MAX);

   // unsigned byte minus the bias, sign extended
   assign byte_val = req_sample_bits[7:0] - irsr_pkg::BYTE_BIAS;
   assign conv_val = wide_samples_ff ? req_sample_bits : {{(SW-8){byte_val[7]}}, byte_val};

   assign emit_fire = cmd.emit && (copies_ff != '0) && (!rsp_valid_ff || !rsp_stall);

   always_comb begin
      source_rate_in   = source_rate_ff;
      output_rate_in   = output_rate_ff;
      source_stereo_in = source_stereo_ff;
      output_stereo_in = output_stereo_ff;
      wide_samples_in  = wide_samples_ff;
      if (csr_wr) begin
         case (csr_index)
            irsr_pkg::REG_SOURCE_RATE:   source_rate_in   = csr_pwdata[RW-1:0];
            irsr_pkg::REG_OUTPUT_RATE:   output_rate_in   = csr_pwdata[RW-1:0];
            irsr_pkg::REG_SOURCE_STEREO: source_stereo_in = csr_pwdata[0];
            irsr_pkg::REG_OUTPUT_STEREO: output_stereo_in = csr_pwdata[0];
            irsr_pkg::REG_WIDE_SAMPLES:  wide_samples_in  = csr_pwdata[0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (csr_index)
         irsr_pkg::REG_SOURCE_RATE:   csr_prdata = 32'(source_rate_ff);
         irsr_pkg::REG_OUTPUT_RATE:   csr_prdata = 32'(output_rate_ff);
         irsr_pkg::REG_SOURCE_STEREO: csr_prdata = 32'(source_stereo_ff);
         irsr_pkg::REG_OUTPUT_STEREO: csr_prdata = 32'(output_stereo_ff);
         irsr_pkg::REG_WIDE_SAMPLES:  csr_prdata = 32'(wide_samples_ff);
         default:                     csr_prdata = '0;
      endcase
   end

   // divider: repeated subtraction, quotient saturates at the ratio limit
   always_comb begin
      rem_in          = rem_ff;
      divisor_in      = divisor_ff;
      quot_in         = quot_ff;
      div_mode_in     = div_mode_ff;
      step_ratio_in   = step_ratio_ff;
      repeat_ratio_in = repeat_ratio_ff;
      if (cmd.div_init) begin
         step_ratio_in   = RATIO_ONE;
         repeat_ratio_in = RATIO_ONE;
         quot_in         = '0;
         if (eff_rate > out_rate) begin
            div_mode_in = irsr_pkg::DIV_INC;
            rem_in      = eff_rate;
            divisor_in  = out_rate;
         end else if (eff_rate < out_rate) begin
            div_mode_in = irsr_pkg::DIV_DUP;
            rem_in      = out_rate;
            divisor_in  = eff_rate;
         end else begin
            div_mode_in = irsr_pkg::DIV_NONE;
            rem_in      = '0;
            divisor_in  = EW'(1);
         end
         // zero divisor saturates straight away
         if (divisor_in == '0) begin
            quot_in    = RATIO_MAX;
            divisor_in = EW'(1);
         end
      end else if (cmd.div_step) begin
         if (!div_done) begin
            rem_in  = rem_ff - divisor_ff;
            quot_in = quot_ff + RATIO_ONE;
         end else if (div_mode_ff == irsr_pkg::DIV_INC) begin
            step_ratio_in = quot_ff;
         end else if (div_mode_ff == irsr_pkg::DIV_DUP) begin
            repeat_ratio_in = quot_ff;
         end
      end
   end

   always_comb begin
      skip_phase_in = skip_phase_ff;
      copies_in     = copies_ff;
      value_in      = value_ff;
      if (csr_wr) begin
         skip_phase_in = '0;
      end else if (cmd.accept) begin
         value_in  = conv_val;
         copies_in = (skip_phase_ff == '0) ? repeat_ratio_ff : '0;
         if (req_sound_end || (skip_phase_ff + RATIO_ONE >= step_ratio_ff)) begin
            skip_phase_in = '0;
         end else begin
            skip_phase_in = skip_phase_ff + RATIO_ONE;
         end
      end else if (emit_fire) begin
         copies_in = copies_ff - RATIO_ONE;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_pcm_in   = rsp_pcm_ff;
      rsp_last_in  = rsp_last_ff;
      if (emit_fire) begin
         rsp_valid_in = 1'b1;
         rsp_pcm_in   = value_ff;
         rsp_last_in  = (copies_ff == RATIO_ONE);
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         source_rate_ff   <= irsr_pkg::RESET_RATE;
         output_rate_ff   <= irsr_pkg::RESET_RATE;
         source_stereo_ff <= 1'b0;
         output_stereo_ff <= 1'b0;
         wide_samples_ff  <= 1'b1;
         step_ratio_ff    <= RATIO_ONE;
         repeat_ratio_ff  <= RATIO_ONE;
         skip_phase_ff    <= '0;
         copies_ff        <= '0;
         rsp_valid_ff     <= 1'b0;
         div_mode_ff      <= irsr_pkg::DIV_NONE;
      end else begin
         source_rate_ff   <= source_rate_in;
         output_rate_ff   <= output_rate_in;
         source_stereo_ff <= source_stereo_in;
         output_stereo_ff <= output_stereo_in;
         wide_samples_ff  <= wide_samples_in;
         step_ratio_ff    <= step_ratio_in;
         repeat_ratio_ff  <= repeat_ratio_in;
         skip_phase_ff    <= skip_phase_in;
         copies_ff        <= copies_in;
         rsp_valid_ff     <= rsp_valid_in;
         div_mode_ff      <= div_mode_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff     <= rem_in;
      divisor_ff <= divisor_in;
      quot_ff    <= quot_in;
      value_ff   <= value_in;
      rsp_pcm_ff <= rsp_pcm_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign status.cfg_write   = csr_wr;
   assign status.div_done    = div_done;
   assign status.copies_zero = (copies_ff == '0);

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_pcm_out  = rsp_pcm_ff;
   assign rsp_run_last = rsp_last_ff;

endmodule

// ----- sv/irsr_controller.sv -----
module irsr_controller (
   input  logic                     clock,
   input  logic                     reset,
   input  irsr_pkg::ctl_status_type status,
   output irsr_pkg::ctl_cmd_type    cmd,
   input  logic                     req_valid,
   output logic                     req_stall
);

   localparam logic [1:0] ST_IDLE     = 2'd0;
   localparam logic [1:0] ST_DIV_INIT = 2'd1;
   localparam logic [1:0] ST_DIV_RUN  = 2'd2;
   localparam logic [1:0] ST_EMIT     = 2'd3;

   logic [1:0] state_ff, state_in;

   assign req_stall = (state_ff != ST_IDLE) || status.cfg_write;

   always_comb begin
      state_in     = state_ff;
      cmd.div_init = 1'b0;
      cmd.div_step = 1'b0;
      cmd.accept   = 1'b0;
      cmd.emit     = 1'b0;
      // a register write always restarts the ratio computation
      if (status.cfg_write) begin
         state_in = ST_DIV_INIT;
      end else begin
         case (state_ff)
            ST_IDLE: begin
               if (req_valid) begin
                  cmd.accept = 1'b1;
                  state_in   = ST_EMIT;
               end
            end
            ST_DIV_INIT: begin
               cmd.div_init = 1'b1;
               state_in     = ST_DIV_RUN;
            end
            ST_DIV_RUN: begin
               // on done the step commits the quotient
               cmd.div_step = 1'b1;
               if (status.div_done) begin
                  state_in = ST_IDLE;
               end
            end
            ST_EMIT: begin
               cmd.emit = 1'b1;
               if (status.copies_zero) begin
                  state_in = ST_IDLE;
               end
            end
            default: state_in = ST_IDLE;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule
